>>> rtl/core/quad_x_motor_mixer_defines.svh
// assertion macros for the quad x motor mixer
`ifndef QUAD_X_MOTOR_MIXER_DEFINES_SVH
`define QUAD_X_MOTOR_MIXER_DEFINES_SVH

`ifndef SYNTHESIS
`define MXR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`define MXR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MXR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define MXR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/mxr_pkg.sv
// shared types, widths and constants of the motor mixer
package mxr_pkg;

	localparam int FRAC_BITS = 8;
	localparam int Q8_SHIFT = 8;
	localparam int US_W = 12;
	localparam int CORR_W = 16;
	localparam int GAIN_W = 8;
	localparam int WGT_W = 9;
	localparam int TICK_W = 10;
	localparam int CLAMP_W = 11;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int FT_W = CLAMP_W + FRAC_BITS;
	localparam int MUL_A_W = (FT_W + 1 > CORR_W + 1) ? FT_W + 1 : CORR_W + 1;
	localparam int MUL_B_W = WGT_W + 1;
	localparam int PROD_W = MUL_A_W + MUL_B_W;
	localparam int GPROD_W = CORR_W + GAIN_W + 1;
	localparam int MIX_W = ((FT_W + 1 > GPROD_W) ? FT_W + 1 : GPROD_W) + 2;
	localparam int PUL_W = MIX_W - FRAC_BITS;

	localparam logic [WGT_W-1:0] Q8_ONE = WGT_W'(256);
	localparam logic [WGT_W-1:0] THIRD_Q8 = WGT_W'(84);

	localparam logic [US_W-1:0] THR_MIN_US = US_W'(1000);
	localparam logic [US_W-1:0] THR_MAX_US = US_W'(2000);
	localparam logic [US_W-1:0] LOW_THR_US = US_W'(1050);
	localparam logic [US_W-1:0] CENTRE_US = US_W'(1500);
	localparam logic [US_W-1:0] CLEAR_US = US_W'(1100);
	localparam logic [US_W-1:0] STOP_US = US_W'(1001);
	localparam logic [US_W-1:0] PULSE_MAX = US_W'(4095);
	localparam logic [TICK_W-1:0] TICK_MAX = TICK_W'(1023);

	localparam logic [FT_W-1:0] THR_MIN_Q = FT_W'(1000 * (1 << FRAC_BITS));
	localparam logic [FT_W-1:0] KNEE_Q = FT_W'(1100 * (1 << FRAC_BITS));
	localparam logic [FT_W-1:0] LOW_BASE_Q = FT_W'(1050 * (1 << FRAC_BITS));
	localparam logic [FT_W-1:0] HIGH_BASE_Q = FT_W'(1350 * (1 << FRAC_BITS));

	typedef enum logic [2:0] {
		REG_IDLE_PULSE = 3'd0,
		REG_ROLL_GAIN  = 3'd1,
		REG_PITCH_GAIN = 3'd2,
		REG_YAW_GAIN   = 3'd3,
		REG_THR_KEEP   = 3'd4,
		REG_CORR_NEW   = 3'd5,
		REG_IDLE_LIMIT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [US_W-1:0]   idle_pulse_us;
		logic [GAIN_W-1:0] roll_gain;
		logic [GAIN_W-1:0] pitch_gain;
		logic [GAIN_W-1:0] yaw_gain;
		logic [WGT_W-1:0]  throttle_keep_q8;
		logic [WGT_W-1:0]  correction_new_q8;
		logic [TICK_W-1:0] idle_tick_limit;
	} cfg_t;

	localparam logic [US_W-1:0] RST_IDLE_PULSE = US_W'(1050);
	localparam logic [GAIN_W-1:0] RST_ROLL_GAIN = GAIN_W'(20);
	localparam logic [GAIN_W-1:0] RST_PITCH_GAIN = GAIN_W'(20);
	localparam logic [GAIN_W-1:0] RST_YAW_GAIN = GAIN_W'(10);
	localparam logic [WGT_W-1:0] RST_THR_KEEP = WGT_W'(102);
	localparam logic [WGT_W-1:0] RST_CORR_NEW = WGT_W'(205);
	localparam logic [TICK_W-1:0] RST_IDLE_LIMIT = TICK_W'(20);

	typedef enum logic [3:0] {
		STEP_NONE,
		STEP_THR,
		STEP_YAW,
		STEP_PITCH,
		STEP_ROLL,
		STEP_BASE,
		STEP_GYAW,
		STEP_GPITCH,
		STEP_GROLL
	} step_t;

	typedef struct packed {
		logic  load;
		step_t mul;
		step_t commit;
		logic  finish;
	} mxr_cmd_t;

endpackage

>>> rtl/core/mxr_cfg.sv
// configuration register file behind the apb port
module mxr_cfg import mxr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite && pready;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_pulse_us <= RST_IDLE_PULSE;
			cfg_q.roll_gain <= RST_ROLL_GAIN;
			cfg_q.pitch_gain <= RST_PITCH_GAIN;
			cfg_q.yaw_gain <= RST_YAW_GAIN;
			cfg_q.throttle_keep_q8 <= RST_THR_KEEP;
			cfg_q.correction_new_q8 <= RST_CORR_NEW;
			cfg_q.idle_tick_limit <= RST_IDLE_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_IDLE_PULSE: cfg_q.idle_pulse_us <= pwdata[US_W-1:0];
				REG_ROLL_GAIN:  cfg_q.roll_gain <= pwdata[GAIN_W-1:0];
				REG_PITCH_GAIN: cfg_q.pitch_gain <= pwdata[GAIN_W-1:0];
				REG_YAW_GAIN:   cfg_q.yaw_gain <= pwdata[GAIN_W-1:0];
				REG_THR_KEEP:   cfg_q.throttle_keep_q8 <= pwdata[WGT_W-1:0];
				REG_CORR_NEW:   cfg_q.correction_new_q8 <= pwdata[WGT_W-1:0];
				REG_IDLE_LIMIT: cfg_q.idle_tick_limit <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_IDLE_PULSE: prdata = DATA_W'(cfg_q.idle_pulse_us);
			REG_ROLL_GAIN:  prdata = DATA_W'(cfg_q.roll_gain);
			REG_PITCH_GAIN: prdata = DATA_W'(cfg_q.pitch_gain);
			REG_YAW_GAIN:   prdata = DATA_W'(cfg_q.yaw_gain);
			REG_THR_KEEP:   prdata = DATA_W'(cfg_q.throttle_keep_q8);
			REG_CORR_NEW:   prdata = DATA_W'(cfg_q.correction_new_q8);
			REG_IDLE_LIMIT: prdata = DATA_W'(cfg_q.idle_tick_limit);
			default:        prdata = '0;
		endcase
	end

endmodule

>>> rtl/core/mxr_ctrl.sv
// sequencer that steps the shared multiplier through one tick
module mxr_ctrl import mxr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output mxr_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_THR,
		ST_YAW,
		ST_PITCH,
		ST_ROLL,
		ST_BASE,
		ST_GYAW,
		ST_GPITCH,
		ST_GROLL,
		ST_LAST,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept_in;
	logic   out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept_in = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// multiply issued this cycle, product of the step before is folded in
	always_comb begin
		cmd.load = accept_in;
		cmd.finish = (state_q == ST_FIN) && out_free;
		unique case (state_q)
			ST_THR:    begin cmd.mul = STEP_THR;    cmd.commit = STEP_NONE;   end
			ST_YAW:    begin cmd.mul = STEP_YAW;    cmd.commit = STEP_THR;    end
			ST_PITCH:  begin cmd.mul = STEP_PITCH;  cmd.commit = STEP_YAW;    end
			ST_ROLL:   begin cmd.mul = STEP_ROLL;   cmd.commit = STEP_PITCH;  end
			ST_BASE:   begin cmd.mul = STEP_BASE;   cmd.commit = STEP_ROLL;   end
			ST_GYAW:   begin cmd.mul = STEP_GYAW;   cmd.commit = STEP_BASE;   end
			ST_GPITCH: begin cmd.mul = STEP_GPITCH; cmd.commit = STEP_GYAW;   end
			ST_GROLL:  begin cmd.mul = STEP_GROLL;  cmd.commit = STEP_GPITCH; end
			ST_LAST:   begin cmd.mul = STEP_NONE;   cmd.commit = STEP_GROLL;  end
			default:   begin cmd.mul = STEP_NONE;   cmd.commit = STEP_NONE;   end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:   if (accept_in) state_q <= ST_THR;
				ST_THR:    state_q <= ST_YAW;
				ST_YAW:    state_q <= ST_PITCH;
				ST_PITCH:  state_q <= ST_ROLL;
				ST_ROLL:   state_q <= ST_BASE;
				ST_BASE:   state_q <= ST_GYAW;
				ST_GYAW:   state_q <= ST_GPITCH;
				ST_GPITCH: state_q <= ST_GROLL;
				ST_GROLL:  state_q <= ST_LAST;
				ST_LAST:   state_q <= ST_FIN;
				ST_FIN:    if (out_free) state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/mxr_dp.sv
// filter, base curve and mixing datapath around one shared multiplier
module mxr_dp import mxr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  mxr_cmd_t                 cmd,
	input  cfg_t                     cfg,
	input  logic [US_W-1:0]          throttle_us,
	input  logic signed [CORR_W-1:0] yaw_correction,
	input  logic signed [CORR_W-1:0] pitch_correction,
	input  logic signed [CORR_W-1:0] roll_correction,
	output logic [US_W-1:0]          pulse_front_left,
	output logic [US_W-1:0]          pulse_front_right,
	output logic [US_W-1:0]          pulse_rear_left,
	output logic [US_W-1:0]          pulse_rear_right,
	output logic                     clear_integrators
);

	localparam int AX_YAW = 0;
	localparam int AX_PITCH = 1;
	localparam int AX_ROLL = 2;

	// motor order: front left, front right, rear left, rear right
	localparam logic [3:0] YAW_NEG = 4'b0110;
	localparam logic [3:0] PITCH_NEG = 4'b0011;
	localparam logic [3:0] ROLL_NEG = 4'b1010;

	logic [US_W-1:0]          raw_q;
	logic signed [CORR_W-1:0] corr_q [3];
	logic [FT_W-1:0]          ft_q;
	logic signed [CORR_W-1:0] fc_q [3];
	logic [TICK_W-1:0]        ticks_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MIX_W-1:0]  mix_q [4];
	logic [US_W-1:0]          pulse_q [4];
	logic                     clr_q;

	logic [CLAMP_W-1:0]        clamped_us;
	logic [FT_W-1:0]           clamp_q8;
	logic [WGT_W-1:0]          keep_w;
	logic [WGT_W-1:0]          fresh_w;
	logic signed [MUL_A_W-1:0] mul_a;
	logic [WGT_W-1:0]          mul_b;
	logic signed [MUL_B_W-1:0] mul_b_s;
	logic signed [PROD_W-1:0]  prod_sh;
	logic signed [PROD_W-1:0]  ft_nx;
	logic [1:0]                fc_ax;
	logic signed [PROD_W-1:0]  fc_nx;
	logic [FT_W-1:0]           low_off;
	logic [FT_W-1:0]           base_v;
	logic signed [MIX_W-1:0]   gadd;
	logic [3:0]                neg_mask;
	logic                      low_thr;
	logic                      centre;
	logic [TICK_W-1:0]         ticks_inc;
	logic [TICK_W-1:0]         ticks_nx;
	logic                      stop;
	logic signed [US_W:0]      idle_s;
	logic signed [PUL_W-1:0]   us_v [4];
	logic [US_W-1:0]           pulse_nx [4];

	always_comb begin
		if (raw_q < THR_MIN_US) begin
			clamped_us = CLAMP_W'(THR_MIN_US);
		end else if (raw_q > THR_MAX_US) begin
			clamped_us = CLAMP_W'(THR_MAX_US);
		end else begin
			clamped_us = raw_q[CLAMP_W-1:0];
		end
	end
	assign clamp_q8 = {clamped_us, FRAC_BITS'(0)};

	assign keep_w = (cfg.throttle_keep_q8 > Q8_ONE) ? Q8_ONE : cfg.throttle_keep_q8;
	assign fresh_w = (cfg.correction_new_q8 > Q8_ONE) ? Q8_ONE : cfg.correction_new_q8;

	// one product per filter: throttle new+k*(old-new), axes old+w*(new-old)
	always_comb begin
		unique case (cmd.mul)
			STEP_THR: begin
				mul_a = MUL_A_W'($signed({1'b0, ft_q})) - MUL_A_W'($signed({1'b0, clamp_q8}));
				mul_b = keep_w;
			end
			STEP_YAW: begin
				mul_a = MUL_A_W'(corr_q[AX_YAW]) - MUL_A_W'(fc_q[AX_YAW]);
				mul_b = fresh_w;
			end
			STEP_PITCH: begin
				mul_a = MUL_A_W'(corr_q[AX_PITCH]) - MUL_A_W'(fc_q[AX_PITCH]);
				mul_b = fresh_w;
			end
			STEP_ROLL: begin
				mul_a = MUL_A_W'(corr_q[AX_ROLL]) - MUL_A_W'(fc_q[AX_ROLL]);
				mul_b = fresh_w;
			end
			STEP_BASE: begin
				mul_a = MUL_A_W'($signed({1'b0, ft_q})) - MUL_A_W'($signed({1'b0, KNEE_Q}));
				mul_b = THIRD_Q8;
			end
			STEP_GYAW: begin
				mul_a = MUL_A_W'(fc_q[AX_YAW]);
				mul_b = WGT_W'(cfg.yaw_gain);
			end
			STEP_GPITCH: begin
				mul_a = MUL_A_W'(fc_q[AX_PITCH]);
				mul_b = WGT_W'(cfg.pitch_gain);
			end
			STEP_GROLL: begin
				mul_a = MUL_A_W'(fc_q[AX_ROLL]);
				mul_b = WGT_W'(cfg.roll_gain);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_b_s = $signed({1'b0, mul_b});

	assign prod_sh = prod_q >>> Q8_SHIFT;
	assign ft_nx = PROD_W'($signed({1'b0, clamp_q8})) + prod_sh;

	always_comb begin
		unique case (cmd.commit)
			STEP_PITCH: fc_ax = 2'(AX_PITCH);
			STEP_ROLL:  fc_ax = 2'(AX_ROLL);
			default:    fc_ax = 2'(AX_YAW);
		endcase
	end
	assign fc_nx = PROD_W'(fc_q[fc_ax]) + prod_sh;

	// two-piece base curve, product here is the slope term of the upper piece
	assign low_off = ft_q - THR_MIN_Q;
	assign base_v = (ft_q > KNEE_Q) ? HIGH_BASE_Q + prod_sh[FT_W-1:0]
		: LOW_BASE_Q + (low_off << 1);

	assign gadd = MIX_W'(prod_q);
	always_comb begin
		unique case (cmd.commit)
			STEP_GYAW:   neg_mask = YAW_NEG;
			STEP_GPITCH: neg_mask = PITCH_NEG;
			default:     neg_mask = ROLL_NEG;
		endcase
	end

	assign low_thr = raw_q < LOW_THR_US;
	assign centre = raw_q == CENTRE_US;
	assign ticks_inc = (ticks_q == TICK_MAX) ? ticks_q : ticks_q + TICK_W'(1);
	assign ticks_nx = (low_thr || centre) ? ticks_inc : '0;
	assign stop = ticks_nx >= cfg.idle_tick_limit;
	assign idle_s = $signed({1'b0, cfg.idle_pulse_us});

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			us_v[k] = mix_q[k][MIX_W-1:FRAC_BITS];
			if (stop) begin
				pulse_nx[k] = STOP_US;
			end else if (low_thr || (us_v[k] < idle_s)) begin
				pulse_nx[k] = cfg.idle_pulse_us;
			end else if (us_v[k] > $signed({1'b0, PULSE_MAX})) begin
				pulse_nx[k] = PULSE_MAX;
			end else begin
				pulse_nx[k] = us_v[k][US_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b_s;
		if (cmd.load) begin
			raw_q <= throttle_us;
			corr_q[AX_YAW] <= yaw_correction;
			corr_q[AX_PITCH] <= pitch_correction;
			corr_q[AX_ROLL] <= roll_correction;
		end
		if (cmd.commit == STEP_BASE) begin
			for (int k = 0; k < 4; k++) begin
				mix_q[k] <= MIX_W'({1'b0, base_v});
			end
		end else if ((cmd.commit == STEP_GYAW) || (cmd.commit == STEP_GPITCH)
			|| (cmd.commit == STEP_GROLL)) begin
			for (int k = 0; k < 4; k++) begin
				mix_q[k] <= neg_mask[k] ? mix_q[k] - gadd : mix_q[k] + gadd;
			end
		end
		if (cmd.finish) begin
			for (int k = 0; k < 4; k++) begin
				pulse_q[k] <= pulse_nx[k];
			end
			clr_q <= raw_q < CLEAR_US;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ft_q <= THR_MIN_Q;
			fc_q[AX_YAW] <= '0;
			fc_q[AX_PITCH] <= '0;
			fc_q[AX_ROLL] <= '0;
			ticks_q <= '0;
		end else begin
			if (cmd.commit == STEP_THR) begin
				ft_q <= ft_nx[FT_W-1:0];
			end
			if ((cmd.commit == STEP_YAW) || (cmd.commit == STEP_PITCH)
				|| (cmd.commit == STEP_ROLL)) begin
				fc_q[fc_ax] <= fc_nx[CORR_W-1:0];
			end
			if (cmd.finish) begin
				ticks_q <= ticks_nx;
			end
		end
	end

	assign pulse_front_left = pulse_q[0];
	assign pulse_front_right = pulse_q[1];
	assign pulse_rear_left = pulse_q[2];
	assign pulse_rear_right = pulse_q[3];
	assign clear_integrators = clr_q;

endmodule

>>> rtl/core/quad_x_motor_mixer.sv
// quad x motor mixer top level: apb registers, sequencer and datapath
// out_valid rises as the sequencer leaves ST_FIN with the output free
// a tick steps the eight products through one shared 20x10 multiplier
//   plus load and output steps; no new tick is taken until it ends
// a finished result waits in the output register while the next tick runs
// reset: registers return to their defaults, filters to 1000 us and zero
module quad_x_motor_mixer import mxr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [US_W-1:0]          throttle_us,
	input  logic signed [CORR_W-1:0] yaw_correction,
	input  logic signed [CORR_W-1:0] pitch_correction,
	input  logic signed [CORR_W-1:0] roll_correction,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [US_W-1:0]          pulse_front_left,
	output logic [US_W-1:0]          pulse_front_right,
	output logic [US_W-1:0]          pulse_rear_left,
	output logic [US_W-1:0]          pulse_rear_right,
	output logic                     clear_integrators,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output logic [DATA_W-1:0]        prdata,
	output logic                     pready
);

`include "quad_x_motor_mixer_defines.svh"

	cfg_t     cfg;
	mxr_cmd_t cmd;

	mxr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mxr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	mxr_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg               (cfg),
		.throttle_us       (throttle_us),
		.yaw_correction    (yaw_correction),
		.pitch_correction  (pitch_correction),
		.roll_correction   (roll_correction),
		.pulse_front_left  (pulse_front_left),
		.pulse_front_right (pulse_front_right),
		.pulse_rear_left   (pulse_rear_left),
		.pulse_rear_right  (pulse_rear_right),
		.clear_integrators (clear_integrators)
	);

	// an accepted transaction keeps the block busy on the next cycle
	`MXR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "block not busy after input transaction")
	// a new result only comes out of a running tick
	`MXR_ASSERT_SAME(a_result_from_tick, clk, arst_n, $rose(out_valid), $past(in_stall), "result appeared without a running tick")
	// while idle, a taken result is not followed by another one
	`MXR_ASSERT_NEXT(a_no_spurious_result, clk, arst_n, out_valid && !out_stall && !in_stall, !out_valid, "result produced while idle")

endmodule

>>> tb/sv/quad_x_motor_mixer_check.sv
// checker for the quad x motor mixer: tracks the registers, predicts every tick, compares pulses and the clear flag
module quad_x_motor_mixer_check import mxr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [US_W-1:0]          throttle_us,
	input  logic signed [CORR_W-1:0] yaw_correction,
	input  logic signed [CORR_W-1:0] pitch_correction,
	input  logic signed [CORR_W-1:0] roll_correction,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic [US_W-1:0]          pulse_front_left,
	input  logic [US_W-1:0]          pulse_front_right,
	input  logic [US_W-1:0]          pulse_rear_left,
	input  logic [US_W-1:0]          pulse_rear_right,
	input  logic                     clear_integrators,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic                     pready,
	input  logic [ADDR_W-1:0]        paddr,
	input  logic [DATA_W-1:0]        pwdata,
	output int                       mismatches,
	output int                       ticks_in_flight,
	output int                       results_checked
);

	localparam longint ONE_US = longint'(1) <<< FRAC_BITS;

	typedef struct packed {
		logic [US_W-1:0] front_left;
		logic [US_W-1:0] front_right;
		logic [US_W-1:0] rear_left;
		logic [US_W-1:0] rear_right;
		logic            clear_int;
	} pulse_set_t;

	cfg_t       cur_cfg;
	longint     thr_q;
	longint     yaw_q;
	longint     pitch_q;
	longint     roll_q;
	int         idle_count;
	int         got_count;
	pulse_set_t pulses_due[$];

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		mismatches++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
				got_count, name, got, want));
	endtask

	// q8 weighted blend, floor rounding
	function automatic longint lowpass(input longint prev, input longint sample,
			input longint w_new);
		return (w_new * sample + (longint'(Q8_ONE) - w_new) * prev) >>> Q8_SHIFT;
	endfunction

	function automatic longint clip_weight(input logic [WGT_W-1:0] w);
		return (w > Q8_ONE) ? longint'(Q8_ONE) : longint'(w);
	endfunction

	function automatic logic [US_W-1:0] q_to_us(input longint q);
		longint us;
		if (q < 0)
			return '0;
		us = q >>> FRAC_BITS;
		return (us > longint'(PULSE_MAX)) ? PULSE_MAX : US_W'(us);
	endfunction

	// one control tick: updates the filters and idle count, returns the motor pulses and clear flag
	function automatic pulse_set_t mix_tick(input logic [US_W-1:0] thr,
			input logic signed [CORR_W-1:0] yaw, input logic signed [CORR_W-1:0] pitch,
			input logic signed [CORR_W-1:0] roll);
		longint raw, clamped, keep, fresh, base, dy, dp, dr, floor_q;
		longint m[4];
		pulse_set_t r;
		raw = longint'(thr);
		clamped = raw;
		if (raw < longint'(THR_MIN_US))
			clamped = longint'(THR_MIN_US);
		else if (raw > longint'(THR_MAX_US))
			clamped = longint'(THR_MAX_US);
		keep = clip_weight(cur_cfg.throttle_keep_q8);
		fresh = clip_weight(cur_cfg.correction_new_q8);

		thr_q = lowpass(thr_q, clamped * ONE_US, longint'(Q8_ONE) - keep);
		yaw_q = lowpass(yaw_q, longint'(yaw), fresh);
		pitch_q = lowpass(pitch_q, longint'(pitch), fresh);
		roll_q = lowpass(roll_q, longint'(roll), fresh);

		if (thr_q > longint'(KNEE_Q))
			base = longint'(HIGH_BASE_Q) +
				(((thr_q - longint'(KNEE_Q)) * longint'(THIRD_Q8)) >>> Q8_SHIFT);
		else
			base = longint'(LOW_BASE_Q) + (thr_q - longint'(THR_MIN_Q)) * 2;

		dy = longint'(cur_cfg.yaw_gain) * yaw_q;
		dp = longint'(cur_cfg.pitch_gain) * pitch_q;
		dr = longint'(cur_cfg.roll_gain) * roll_q;

		m[0] = base - dp + dr + dy;
		m[1] = base - dp - dr - dy;
		m[2] = base + dp + dr - dy;
		m[3] = base + dp - dr + dy;

		floor_q = longint'(cur_cfg.idle_pulse_us) * ONE_US;
		foreach (m[i])
			if (m[i] < floor_q)
				m[i] = floor_q;

		if (raw < longint'(LOW_THR_US)) begin
			foreach (m[i])
				m[i] = floor_q;
			if (idle_count < int'(TICK_MAX))
				idle_count++;
		end else if (raw == longint'(CENTRE_US)) begin
			if (idle_count < int'(TICK_MAX))
				idle_count++;
		end else begin
			idle_count = 0;
		end

		if (idle_count >= int'(cur_cfg.idle_tick_limit))
			foreach (m[i])
				m[i] = longint'(STOP_US) * ONE_US;

		r.front_left = q_to_us(m[0]);
		r.front_right = q_to_us(m[1]);
		r.rear_left = q_to_us(m[2]);
		r.rear_right = q_to_us(m[3]);
		r.clear_int = raw < longint'(CLEAR_US);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pulse_set_t want;
		if (!arst_n) begin
			cur_cfg = '{idle_pulse_us: RST_IDLE_PULSE, roll_gain: RST_ROLL_GAIN,
				pitch_gain: RST_PITCH_GAIN, yaw_gain: RST_YAW_GAIN,
				throttle_keep_q8: RST_THR_KEEP, correction_new_q8: RST_CORR_NEW,
				idle_tick_limit: RST_IDLE_LIMIT};
			thr_q = longint'(THR_MIN_Q);
			yaw_q = 0;
			pitch_q = 0;
			roll_q = 0;
			idle_count = 0;
			got_count = 0;
			mismatches = 0;
			pulses_due.delete();
			ticks_in_flight <= 0;
			results_checked <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pulses_due.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no tick outstanding",
						got_count));
				end else begin
					want = pulses_due.pop_front();
					check_field("front left", int'(pulse_front_left),
						int'(want.front_left));
					check_field("front right", int'(pulse_front_right),
						int'(want.front_right));
					check_field("rear left", int'(pulse_rear_left),
						int'(want.rear_left));
					check_field("rear right", int'(pulse_rear_right),
						int'(want.rear_right));
					check_field("clear integrators", int'(clear_integrators),
						int'(want.clear_int));
				end
				got_count++;
			end
			if (in_valid && !in_stall)
				pulses_due.push_back(mix_tick(throttle_us, yaw_correction,
					pitch_correction, roll_correction));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_IDLE_PULSE: cur_cfg.idle_pulse_us = pwdata[US_W-1:0];
					REG_ROLL_GAIN:  cur_cfg.roll_gain = pwdata[GAIN_W-1:0];
					REG_PITCH_GAIN: cur_cfg.pitch_gain = pwdata[GAIN_W-1:0];
					REG_YAW_GAIN:   cur_cfg.yaw_gain = pwdata[GAIN_W-1:0];
					REG_THR_KEEP:   cur_cfg.throttle_keep_q8 = pwdata[WGT_W-1:0];
					REG_CORR_NEW:   cur_cfg.correction_new_q8 = pwdata[WGT_W-1:0];
					REG_IDLE_LIMIT: cur_cfg.idle_tick_limit = pwdata[TICK_W-1:0];
					default: ;
				endcase
			end
			ticks_in_flight <= pulses_due.size();
			results_checked <= got_count;
		end
	end

endmodule

>>> tb/sv/quad_x_motor_mixer_test.sv
// testbench top for the quad x motor mixer: clock, reset, stimulus and verdict
module quad_x_motor_mixer_test import mxr_pkg::*; ();

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 300;
	localparam cfg_t CFG_DEFAULT = '{idle_pulse_us: RST_IDLE_PULSE,
		roll_gain: RST_ROLL_GAIN, pitch_gain: RST_PITCH_GAIN, yaw_gain: RST_YAW_GAIN,
		throttle_keep_q8: RST_THR_KEEP, correction_new_q8: RST_CORR_NEW,
		idle_tick_limit: RST_IDLE_LIMIT};
	localparam cfg_t CFG_FLOOR = '0;
	localparam cfg_t CFG_CEIL = '1;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [US_W-1:0]          throttle_us = '0;
	logic signed [CORR_W-1:0] yaw_correction = '0;
	logic signed [CORR_W-1:0] pitch_correction = '0;
	logic signed [CORR_W-1:0] roll_correction = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [US_W-1:0]          pulse_front_left;
	logic [US_W-1:0]          pulse_front_right;
	logic [US_W-1:0]          pulse_rear_left;
	logic [US_W-1:0]          pulse_rear_right;
	logic                     clear_integrators;
	logic                     psel = 1'b0;
	logic                     penable = 1'b0;
	logic                     pwrite = 1'b0;
	logic [ADDR_W-1:0]        paddr = '0;
	logic [DATA_W-1:0]        pwdata = '0;
	logic [DATA_W-1:0]        prdata;
	logic                     pready;

	int mismatches;
	int ticks_in_flight;
	int results_checked;
	int cycle_count = 0;
	int gap_max = 0;
	int hold_len = 0;
	int low_run_left = 0;
	int ticks_sent = 0;
	int settings_used = 0;

	always #6 clk = ~clk;

	quad_x_motor_mixer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.throttle_us(throttle_us),
		.yaw_correction(yaw_correction),
		.pitch_correction(pitch_correction),
		.roll_correction(roll_correction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_front_left(pulse_front_left),
		.pulse_front_right(pulse_front_right),
		.pulse_rear_left(pulse_rear_left),
		.pulse_rear_right(pulse_rear_right),
		.clear_integrators(clear_integrators),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	quad_x_motor_mixer_check u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.throttle_us(throttle_us),
		.yaw_correction(yaw_correction),
		.pitch_correction(pitch_correction),
		.roll_correction(roll_correction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_front_left(pulse_front_left),
		.pulse_front_right(pulse_front_right),
		.pulse_rear_left(pulse_rear_left),
		.pulse_rear_right(pulse_rear_right),
		.clear_integrators(clear_integrators),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.pready(pready),
		.paddr(paddr),
		.pwdata(pwdata),
		.mismatches(mismatches),
		.ticks_in_flight(ticks_in_flight),
		.results_checked(results_checked)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d ticks still in flight",
				cycle_count, ticks_in_flight);
			$display("quad_x_motor_mixer test failed");
			$finish;
		end
	end

	// output side: random stall before each transaction, one long hold on request
	initial begin : drain
		int n;
		forever begin
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
			end else begin
				n = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(int'(idx) * 4);
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic apply_settings(input cfg_t c);
		write_reg(REG_IDLE_PULSE, DATA_W'(c.idle_pulse_us));
		write_reg(REG_ROLL_GAIN, DATA_W'(c.roll_gain));
		write_reg(REG_PITCH_GAIN, DATA_W'(c.pitch_gain));
		write_reg(REG_YAW_GAIN, DATA_W'(c.yaw_gain));
		write_reg(REG_THR_KEEP, DATA_W'(c.throttle_keep_q8));
		write_reg(REG_CORR_NEW, DATA_W'(c.correction_new_q8));
		write_reg(REG_IDLE_LIMIT, DATA_W'(c.idle_tick_limit));
		settings_used++;
	endtask

	// wait until every tick has come back and the pipeline has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (ticks_in_flight != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_tick(input logic [US_W-1:0] thr, input logic signed [CORR_W-1:0] yaw,
			input logic signed [CORR_W-1:0] pitch, input logic signed [CORR_W-1:0] roll);
		int gap;
		gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		throttle_us <= thr;
		yaw_correction <= yaw;
		pitch_correction <= pitch;
		roll_correction <= roll;
		do @(posedge clk); while (in_stall);
		ticks_sent++;
	endtask

	function automatic logic signed [CORR_W-1:0] rand_corr();
		case ($urandom_range(7, 0))
			0: return CORR_W'($urandom_range(65535, 0));
			1: begin
				case ($urandom_range(3, 0))
					0: return 16'sh8000;
					1: return 16'sh7FFF;
					2: return 16'sh0000;
					default: return 16'shFFFF;
				endcase
			end
			default: return CORR_W'(int'($urandom_range(8192, 0)) - 4096);
		endcase
	endfunction

	function automatic cfg_t random_settings();
		cfg_t c;
		c.idle_pulse_us = ($urandom_range(3, 0) == 0) ? US_W'($urandom_range(4095, 0)) :
			US_W'($urandom_range(1300, 900));
		c.roll_gain = ($urandom_range(3, 0) == 0) ? GAIN_W'($urandom_range(255, 0)) :
			GAIN_W'($urandom_range(40, 0));
		c.pitch_gain = ($urandom_range(3, 0) == 0) ? GAIN_W'($urandom_range(255, 0)) :
			GAIN_W'($urandom_range(40, 0));
		c.yaw_gain = ($urandom_range(3, 0) == 0) ? GAIN_W'($urandom_range(255, 0)) :
			GAIN_W'($urandom_range(40, 0));
		c.throttle_keep_q8 = ($urandom_range(4, 0) == 0) ? WGT_W'($urandom_range(511, 0)) :
			WGT_W'($urandom_range(256, 0));
		c.correction_new_q8 = ($urandom_range(4, 0) == 0) ? WGT_W'($urandom_range(511, 0)) :
			WGT_W'($urandom_range(256, 0));
		c.idle_tick_limit = TICK_W'($urandom_range(40, 1));
		return c;
	endfunction

	// mostly flying throttle, with runs of low or centre stick to trip the idle counter
	task automatic random_tick();
		logic [US_W-1:0] thr;
		if (low_run_left == 0 && $urandom_range(9, 0) == 0)
			low_run_left = $urandom_range(40, 1);
		if (low_run_left > 0) begin
			low_run_left--;
			thr = ($urandom_range(3, 0) == 0) ? CENTRE_US : US_W'($urandom_range(1049, 0));
		end else begin
			case ($urandom_range(9, 0))
				0: thr = US_W'($urandom_range(4095, 0));
				1: begin
					case ($urandom_range(9, 0))
						0: thr = US_W'(THR_MIN_US - 1);
						1: thr = THR_MIN_US;
						2: thr = US_W'(LOW_THR_US - 1);
						3: thr = LOW_THR_US;
						4: thr = US_W'(CLEAR_US - 1);
						5: thr = CLEAR_US;
						6: thr = CENTRE_US;
						7: thr = THR_MAX_US;
						8: thr = US_W'(THR_MAX_US + 1);
						default: thr = PULSE_MAX;
					endcase
				end
				default: thr = US_W'($urandom_range(2000, 1000));
			endcase
		end
		send_tick(thr, rand_corr(), rand_corr(), rand_corr());
	endtask

	initial begin : stimulus
		cfg_t s;
		int n;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// field extremes and throttle boundaries with the reset settings
		gap_max = 2;
		send_tick(12'd0, 16'sh0000, 16'sh0000, 16'sh0000);
		send_tick(PULSE_MAX, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_tick(US_W'(THR_MIN_US - 1), 16'sh8000, 16'sh8000, 16'sh8000);
		send_tick(THR_MIN_US, 16'sh7FFF, 16'sh8000, 16'sh0100);
		send_tick(US_W'(LOW_THR_US - 1), 16'shFFFF, 16'sh0001, 16'sh0000);
		send_tick(LOW_THR_US, 16'sh1000, 16'shF000, 16'sh0800);
		send_tick(US_W'(CLEAR_US - 1), 16'sh0000, 16'sh0000, 16'sh0000);
		send_tick(CLEAR_US, 16'sh0200, 16'shFE00, 16'sh0300);
		send_tick(US_W'(CLEAR_US + 1), 16'sh5555, 16'shAAAA, 16'sh5555);
		send_tick(CENTRE_US, 16'sh0000, 16'sh0000, 16'sh0000);
		send_tick(THR_MAX_US, 16'shAAAA, 16'sh5555, 16'shAAAA);
		send_tick(US_W'(THR_MAX_US + 1), 16'shFF00, 16'sh00FF, 16'sh8001);
		send_tick(12'd1800, 16'sh0400, 16'sh0400, 16'sh0400);

		// short idle limit, throttle weight above one and correction weight at one
		settle();
		s = CFG_DEFAULT;
		s.idle_tick_limit = TICK_W'(3);
		s.throttle_keep_q8 = WGT_W'(300);
		s.correction_new_q8 = WGT_W'(256);
		apply_settings(s);
		send_tick(CENTRE_US, 16'sh0100, 16'sh0000, 16'shFF00);
		send_tick(CENTRE_US, 16'sh0100, 16'sh0000, 16'shFF00);
		send_tick(CENTRE_US, 16'sh0100, 16'sh0000, 16'shFF00);
		send_tick(12'd1020, 16'sh0000, 16'sh0200, 16'sh0000);
		send_tick(12'd1040, 16'sh0000, 16'sh0200, 16'sh0000);
		send_tick(12'd1600, 16'sh0300, 16'shFD00, 16'sh0100);
		send_tick(12'd0, 16'sh0000, 16'sh0000, 16'sh0000);
		send_tick(US_W'(LOW_THR_US - 1), 16'sh0000, 16'sh0000, 16'sh0000);
		send_tick(US_W'(LOW_THR_US - 1), 16'sh0000, 16'sh0000, 16'sh0000);
		send_tick(12'd1200, 16'sh0080, 16'sh0080, 16'sh0080);

		for (int phase = 0; phase < 7; phase++) begin
			settle();
			case (phase)
				0: s = CFG_FLOOR;
				1: s = CFG_CEIL;
				2: s = CFG_DEFAULT;
				default: s = random_settings();
			endcase
			apply_settings(s);
			low_run_left = 0;
			gap_max = (phase == 2) ? 0 : 14;
			// back-to-back ticks against a stuck output fill the block up
			if (phase == 2)
				hold_len = HOLD_CYCLES;
			n = (phase == 0) ? 40 : (phase == 1) ? 100 : 160;
			repeat (n) random_tick();
		end

		settle();
		$display("sent %0d ticks, checked %0d results over %0d register settings",
			ticks_sent, results_checked, settings_used);
		$display("included low and centre stick runs and a %0d-cycle output hold",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("quad_x_motor_mixer test passed");
		else
			$display("quad_x_motor_mixer test failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mxr_pkg.sv
rtl/core/mxr_cfg.sv
rtl/core/mxr_ctrl.sv
rtl/core/mxr_dp.sv
rtl/core/quad_x_motor_mixer.sv
tb/sv/quad_x_motor_mixer_check.sv
tb/sv/quad_x_motor_mixer_test.sv
